// File: rtl/core/assert_macros.svh
// Concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/core/dpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpc_pkg;

	localparam int TEMP_BITS_DEF  = 12;
	localparam int TIMER_BITS_DEF = 13;

	localparam int DEB_W     = 10;
	localparam int LONG_W    = 13;
	localparam int HYST_W    = 8;
	localparam int STEP_W    = 8;
	localparam int DELTA_W   = 10;
	localparam int CFG_IDX_W = 3;

	localparam int OFF_GAP   = 32;
	localparam int OFF_FLOOR = 8;

	localparam int RST_DEBOUNCE   = 50;
	localparam int RST_LONG_PRESS = 5000;
	localparam int RST_MAN_HYST   = 8;
	localparam int RST_STEP       = 8;
	localparam int RST_DON_MIN    = 16;
	localparam int RST_DON_MAX    = 128;
	localparam int RST_TGT_MIN    = 288;
	localparam int RST_TGT_MAX    = 640;
	localparam int RST_ON_THR     = 48;
	localparam int RST_OFF_THR    = 16;
	localparam int RST_TARGET     = 448;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE   = 3'd0,
		CFG_LONG_PRESS = 3'd1,
		CFG_MAN_HYST   = 3'd2,
		CFG_STEP       = 3'd3,
		CFG_DON_MIN    = 3'd4,
		CFG_DON_MAX    = 3'd5,
		CFG_TGT_MIN    = 3'd6,
		CFG_TGT_MAX    = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		UI_NONE      = 3'd0,
		UI_STEP      = 3'd1,
		UI_MODE      = 3'd2,
		UI_FORCE_ON  = 3'd3,
		UI_FORCE_OFF = 3'd4
	} ui_event_t;

	typedef enum logic [1:0] {
		PE_NONE = 2'd0,
		PE_ON   = 2'd1,
		PE_OFF  = 2'd2
	} pump_event_t;

endpackage

`default_nettype wire

// File: rtl/core/differential_pump_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Differential pump controller, one input transaction per millisecond tick.
// Input channel (in_valid / in_stall): button levels and the inlet and outlet
// temperatures, signed 1/16 degree C. Output channel (out_valid / out_stall):
// exactly one result per input with relay drive, mode flags, thresholds,
// target and the UI / pump event codes of that tick.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index;
// write only while no transaction is in flight.
// A tick held in the input register is processed into the result register
// through one level of compare/add logic, and the state registers update in
// the same pass. One tick per cycle while the result register is not held by
// out_stall, set by that single register-to-register pass and the state feedback.
// Stall: the input register holds one tick while the result register is full
// and stalled; in_stall rises only when both are occupied.
// Reset: configuration returns to its defaults, auto mode, pump off, delta-on
// 3.0, delta-off 1.0, target 28.0 degrees, and both buttons are taken as held
// so that a level already high after reset does not count as a press.
// A hard-manual override, once latched, stays until the next reset.

module differential_pump_controller #(
	parameter int TEMP_BITS  = dpc_pkg::TEMP_BITS_DEF,
	parameter int TIMER_BITS = dpc_pkg::TIMER_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [dpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [((TEMP_BITS > dpc_pkg::LONG_W) ? TEMP_BITS : dpc_pkg::LONG_W)-1:0]
	                                                  cfg_wdata,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 up_pressed,
	input  wire logic                                 down_pressed,
	input  wire logic signed [TEMP_BITS-1:0]          temp_inlet,
	input  wire logic signed [TEMP_BITS-1:0]          temp_outlet,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      relay_on,
	output logic                                      forced_mode,
	output logic                                      auto_mode,
	output logic                                      screen_index,
	output logic [dpc_pkg::DELTA_W-1:0]               on_delta,
	output logic [dpc_pkg::DELTA_W-1:0]               off_delta,
	output logic signed [TEMP_BITS-1:0]               target_level,
	output logic [2:0]                                ui_event,
	output logic [1:0]                                pump_event
);
	import dpc_pkg::*;

	`include "assert_macros.svh"

	localparam int HW  = (TIMER_BITS > LONG_W) ? TIMER_BITS : LONG_W;
	localparam int BW  = (TIMER_BITS > DEB_W) ? TIMER_BITS : DEB_W;
	localparam int TW  = TEMP_BITS + 2;
	localparam int DW  = (TEMP_BITS + 2 > DELTA_W + 2) ? TEMP_BITS + 2 : DELTA_W + 2;
	localparam int AW  = DELTA_W + 2;

	// configuration registers
	logic [DEB_W-1:0]            debounce_q;
	logic [LONG_W-1:0]           long_press_q;
	logic [HYST_W-1:0]           man_hyst_q;
	logic [STEP_W-1:0]           step_q;
	logic [DELTA_W-1:0]          don_min_q;
	logic [DELTA_W-1:0]          don_max_q;
	logic signed [TEMP_BITS-1:0] tgt_min_q;
	logic signed [TEMP_BITS-1:0] tgt_max_q;

	// input register
	logic                        valid_s1;
	logic                        up_s1;
	logic                        dn_s1;
	logic signed [TEMP_BITS-1:0] t_in_s1;
	logic signed [TEMP_BITS-1:0] t_out_s1;

	// controller state
	logic                        mode_q, mode_n;
	logic                        pump_q, pump_n;
	logic                        screen_q, screen_n;
	logic                        forced_q, forced_n;
	logic                        fpump_q, fpump_n;
	logic [DELTA_W-1:0]          on_q, on_n;
	logic [DELTA_W-1:0]          off_q, off_n;
	logic signed [TEMP_BITS-1:0] target_q, target_n;
	logic                        both_act_q, both_act_n;
	logic                        both_done_q, both_done_n;
	logic                        single_act_q, single_act_n;
	logic [TIMER_BITS-1:0]       single_ms_q, single_ms_n;
	logic [TIMER_BITS-1:0]       both_ms_q, both_ms_n;
	logic [DEB_W-1:0]            since_q, since_n;
	logic                        prev_up_q, prev_up_n;
	logic                        prev_dn_q, prev_dn_n;
	ui_event_t                   ui_n;
	pump_event_t                 pe_n;

	// result register
	logic                        out_valid_q;
	logic                        relay_q;
	logic                        forced_out_q;
	logic                        auto_out_q;
	logic                        screen_out_q;
	logic [DELTA_W-1:0]          on_out_q;
	logic [DELTA_W-1:0]          off_out_q;
	logic signed [TEMP_BITS-1:0] target_out_q;
	ui_event_t                   ui_out_q;
	pump_event_t                 pe_out_q;

	logic fire;
	logic in_take;

	// stepped threshold candidates
	logic signed [AW-1:0]        on_sum, on_dif;
	logic [DELTA_W-1:0]          on_up, on_dn, off_up, off_dn;
	logic signed [TW-1:0]        tgt_sum, tgt_dif;
	logic signed [TEMP_BITS-1:0] tgt_up, tgt_dn;

	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign in_take  = in_valid && !in_stall;

	assign on_sum = $signed({2'b00, on_q}) + $signed(AW'(step_q));
	assign on_dif = $signed({2'b00, on_q}) - $signed(AW'(step_q));
	assign on_up  = (on_sum > $signed({2'b00, don_max_q})) ? don_max_q : on_sum[DELTA_W-1:0];
	assign on_dn  = (on_dif < $signed({2'b00, don_min_q})) ? don_min_q : on_dif[DELTA_W-1:0];
	assign off_up = (on_up < DELTA_W'(OFF_GAP + OFF_FLOOR)) ? DELTA_W'(OFF_FLOOR)
	                                                       : on_up - DELTA_W'(OFF_GAP);
	assign off_dn = (on_dn < DELTA_W'(OFF_GAP + OFF_FLOOR)) ? DELTA_W'(OFF_FLOOR)
	                                                       : on_dn - DELTA_W'(OFF_GAP);

	assign tgt_sum = TW'(target_q) + $signed(TW'(step_q));
	assign tgt_dif = TW'(target_q) - $signed(TW'(step_q));
	assign tgt_up  = (tgt_sum > TW'(tgt_max_q)) ? tgt_max_q : tgt_sum[TEMP_BITS-1:0];
	assign tgt_dn  = (tgt_dif < TW'(tgt_min_q)) ? tgt_min_q : tgt_dif[TEMP_BITS-1:0];

	always_comb begin
		logic                 reach_s;
		logic                 reach_b;
		logic                 step_ok;
		logic                 skip;
		logic                 step_up;
		logic                 step_dn;
		logic signed [DW-1:0] diff;
		logic signed [TW-1:0] man_thr;

		mode_n       = mode_q;
		pump_n       = pump_q;
		screen_n     = screen_q;
		forced_n     = forced_q;
		fpump_n      = fpump_q;
		on_n         = on_q;
		off_n        = off_q;
		target_n     = target_q;
		both_act_n   = both_act_q;
		both_done_n  = both_done_q;
		single_act_n = single_act_q;
		single_ms_n  = single_ms_q;
		both_ms_n    = both_ms_q;
		since_n      = since_q;
		prev_up_n    = prev_up_q;
		prev_dn_n    = prev_dn_q;
		ui_n         = UI_NONE;
		pe_n         = PE_NONE;
		reach_s      = 1'b0;
		reach_b      = 1'b0;
		step_ok      = 1'b0;
		skip         = 1'b0;
		step_up      = 1'b0;
		step_dn      = 1'b0;
		diff         = '0;
		man_thr      = '0;

		if (!forced_q) begin
			if (!(&since_q))
				since_n = since_q + 1'b1;
			if (single_act_q && !(&single_ms_q))
				single_ms_n = single_ms_q + 1'b1;
			if (both_act_q && !(&both_ms_q))
				both_ms_n = both_ms_q + 1'b1;

			// one button alone: long hold latches the override
			if (up_s1 != dn_s1) begin
				if (!single_act_q) begin
					single_act_n = 1'b1;
					single_ms_n  = '0;
				end
				reach_s = (HW'(single_ms_n) >= HW'(long_press_q)) || (&single_ms_n);
				if (reach_s) begin
					forced_n = 1'b1;
					fpump_n  = up_s1;
					ui_n     = up_s1 ? UI_FORCE_ON : UI_FORCE_OFF;
					skip     = 1'b1;
				end
			end else begin
				single_act_n = 1'b0;
				single_ms_n  = '0;
			end

			if (!skip && up_s1 && dn_s1) begin
				if (!both_act_q) begin
					both_act_n  = 1'b1;
					both_ms_n   = '0;
					both_done_n = 1'b0;
				end
				reach_b = (HW'(both_ms_n) >= HW'(long_press_q)) || (&both_ms_n);
				if (!both_done_n && reach_b) begin
					both_done_n = 1'b1;
					mode_n      = !mode_q;
					screen_n    = 1'b0;
					ui_n        = UI_MODE;
				end
			end else if (!skip) begin
				step_ok = (since_n > debounce_q) || (&since_n);
				if (!up_s1 && !dn_s1) begin
					// release after a short press of both flips the page
					reach_b = (HW'(both_ms_n) >= HW'(long_press_q)) || (&both_ms_n);
					if (both_act_q && !both_done_q && !reach_b &&
					    BW'(both_ms_n) > BW'(debounce_q)) begin
						screen_n = !screen_q;
						ui_n     = UI_STEP;
					end
					both_act_n  = 1'b0;
					both_done_n = 1'b0;
					both_ms_n   = '0;
				end
				step_up = up_s1 && !dn_s1 && !both_act_q && !prev_up_q && step_ok;
				step_dn = dn_s1 && !up_s1 && !both_act_q && !prev_dn_q && step_ok;
				if (step_up || step_dn) begin
					if (mode_q) begin
						on_n  = step_up ? on_up : on_dn;
						off_n = step_up ? off_up : off_dn;
					end else begin
						target_n = step_up ? tgt_up : tgt_dn;
					end
					since_n = '0;
					ui_n    = UI_STEP;
				end
				prev_up_n = up_s1;
				prev_dn_n = dn_s1;
			end

			if (!forced_n) begin
				if (mode_n) begin
					diff = DW'(t_out_s1) - DW'(t_in_s1);
					if (!pump_q && diff >= $signed(DW'(on_n))) begin
						pump_n = 1'b1;
						pe_n   = PE_ON;
					end else if (pump_q && diff <= $signed(DW'(off_n))) begin
						pump_n = 1'b0;
						pe_n   = PE_OFF;
					end
				end else begin
					man_thr = TW'(target_n) - $signed(TW'(man_hyst_q));
					if (!pump_q && TW'(t_in_s1) < man_thr) begin
						pump_n = 1'b1;
						pe_n   = PE_ON;
					end else if (pump_q && t_in_s1 >= target_n) begin
						pump_n = 1'b0;
						pe_n   = PE_OFF;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEB_W'(RST_DEBOUNCE);
			long_press_q <= LONG_W'(RST_LONG_PRESS);
			man_hyst_q   <= HYST_W'(RST_MAN_HYST);
			step_q       <= STEP_W'(RST_STEP);
			don_min_q    <= DELTA_W'(RST_DON_MIN);
			don_max_q    <= DELTA_W'(RST_DON_MAX);
			tgt_min_q    <= TEMP_BITS'(RST_TGT_MIN);
			tgt_max_q    <= TEMP_BITS'(RST_TGT_MAX);
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE:   debounce_q   <= cfg_wdata[DEB_W-1:0];
				CFG_LONG_PRESS: long_press_q <= cfg_wdata[LONG_W-1:0];
				CFG_MAN_HYST:   man_hyst_q   <= cfg_wdata[HYST_W-1:0];
				CFG_STEP:       step_q       <= cfg_wdata[STEP_W-1:0];
				CFG_DON_MIN:    don_min_q    <= cfg_wdata[DELTA_W-1:0];
				CFG_DON_MAX:    don_max_q    <= cfg_wdata[DELTA_W-1:0];
				CFG_TGT_MIN:    tgt_min_q    <= $signed(cfg_wdata[TEMP_BITS-1:0]);
				CFG_TGT_MAX:    tgt_max_q    <= $signed(cfg_wdata[TEMP_BITS-1:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			up_s1    <= up_pressed;
			dn_s1    <= down_pressed;
			t_in_s1  <= temp_inlet;
			t_out_s1 <= temp_outlet;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b1;
			pump_q       <= 1'b0;
			screen_q     <= 1'b0;
			forced_q     <= 1'b0;
			fpump_q      <= 1'b0;
			on_q         <= DELTA_W'(RST_ON_THR);
			off_q        <= DELTA_W'(RST_OFF_THR);
			target_q     <= TEMP_BITS'(RST_TARGET);
			both_act_q   <= 1'b0;
			both_done_q  <= 1'b0;
			single_act_q <= 1'b0;
			single_ms_q  <= '0;
			both_ms_q    <= '0;
			since_q      <= '0;
			prev_up_q    <= 1'b1;
			prev_dn_q    <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= fire || (out_valid_q && out_stall);
			if (fire) begin
				mode_q       <= mode_n;
				pump_q       <= pump_n;
				screen_q     <= screen_n;
				forced_q     <= forced_n;
				fpump_q      <= fpump_n;
				on_q         <= on_n;
				off_q        <= off_n;
				target_q     <= target_n;
				both_act_q   <= both_act_n;
				both_done_q  <= both_done_n;
				single_act_q <= single_act_n;
				single_ms_q  <= single_ms_n;
				both_ms_q    <= both_ms_n;
				since_q      <= since_n;
				prev_up_q    <= prev_up_n;
				prev_dn_q    <= prev_dn_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			relay_q      <= forced_n ? fpump_n : pump_n;
			forced_out_q <= forced_n;
			auto_out_q   <= mode_n;
			screen_out_q <= screen_n;
			on_out_q     <= on_n;
			off_out_q    <= off_n;
			target_out_q <= target_n;
			ui_out_q     <= ui_n;
			pe_out_q     <= pe_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign relay_on     = relay_q;
	assign forced_mode  = forced_out_q;
	assign auto_mode    = auto_out_q;
	assign screen_index = screen_out_q;
	assign on_delta     = on_out_q;
	assign off_delta    = off_out_q;
	assign target_level = target_out_q;
	assign ui_event     = ui_out_q;
	assign pump_event   = pe_out_q;

	// override is sticky until reset
	`ASSERT_CLK(a_forced_sticky, forced_q |=> forced_q, "override latch dropped")
	// thresholds freeze once the override is latched
	`ASSERT_CLK(a_forced_frozen, forced_q |=> ($stable(on_q) && $stable(target_q) && $stable(mode_q)), "state changed under override")
	// a latching tick reports a forced code and no pump event
	`ASSERT_CLK(a_forced_event, $rose(forced_q) |-> ((ui_out_q == UI_FORCE_ON || ui_out_q == UI_FORCE_OFF) && pe_out_q == PE_NONE), "bad event on override latch")
	// the input register is never overwritten while it holds an unprocessed tick
	`ASSERT_ALWAYS(a_no_overrun, (arst_n && valid_s1 && !fire) |-> !in_take, "input register overrun")

endmodule

`default_nettype wire
